// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the port checker aat_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every edge outside reset.
`define AAT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define AAT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/aat_pkg.sv
// ---------------------------------------------------------------------------
// aat_pkg
// Types, codes and constants of the box affine transform block.
// ---------------------------------------------------------------------------
`default_nettype none

package aat_pkg;

    localparam int FIELD_W          = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int DEPTH_BIAS_W     = 31;
    localparam int DEPTH_BIAS_RESET = 655;
    localparam int NUM_AXES         = 3;
    localparam int NUM_COEFS        = 4;
    localparam int AXIS_W           = 2;
    localparam int ROW_SEL_W        = 2;
    localparam int IN_TDATA_W       = 10 * FIELD_W;
    localparam int IN_TUSER_W       = 1 + ROW_SEL_W;
    localparam int OUT_TDATA_W      = 6 * FIELD_W;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    // tdata field slots of the request channel
    localparam int SLOT_COEF_X  = 0;
    localparam int SLOT_COEF_T  = 3;
    localparam int SLOT_BOX_MIN = 4;
    localparam int SLOT_BOX_MAX = 7;

    localparam logic [ROW_SEL_W-1:0] ROW_NONE       = 2'd3;
    localparam logic [0:0]           REG_DEPTH_BIAS = 1'b0;

    typedef enum logic [0:0] {
        REQ_LOAD = 1'b0,
        REQ_BOX  = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic              load;
        logic              capture;
        logic              issue;
        logic [AXIS_W-1:0] axis;
        logic              push;
    } cmd_t;

    typedef struct packed {
        logic last_done;
    } status_t;

endpackage

`default_nettype wire

// File: hdl/aat_ctrl.sv
// ---------------------------------------------------------------------------
// aat_ctrl
// Sequencer: takes requests, steps the datapath over the three output axes
// and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module aat_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire aat_pkg::req_type_t req_type,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output aat_pkg::cmd_t          cmd,
    input  wire aat_pkg::status_t  status
);

    aat_pkg::state_t                 state_reg, state_next;
    logic [aat_pkg::AXIS_W-1:0]      axis_reg, axis_next;
    logic                            out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= aat_pkg::ST_IDLE;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            aat_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (req_type == aat_pkg::REQ_BOX) begin
                        cmd.capture = 1'b1;
                        axis_next   = '0;
                        state_next  = aat_pkg::ST_ISSUE;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            aat_pkg::ST_ISSUE: begin
                cmd.issue = 1'b1;
                cmd.axis  = axis_reg;
                if (axis_reg == aat_pkg::AXIS_W'(aat_pkg::NUM_AXES - 1)) begin
                    state_next = aat_pkg::ST_WAIT;
                end else begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            aat_pkg::ST_WAIT: begin
                if (status.last_done) begin
                    state_next = aat_pkg::ST_PUSH;
                end
            end
            aat_pkg::ST_PUSH: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.push       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = aat_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aat_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: hdl/aat_datapath.sv
// ---------------------------------------------------------------------------
// aat_datapath
// Matrix store, box registers and the four-stage axis pipeline: products,
// per-coordinate min/max, row sum, widening with saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module aat_datapath #(
    parameter int FRAC_BITS   = aat_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire aat_pkg::cmd_t                     cmd,
    output aat_pkg::status_t                       status,
    input  wire logic [aat_pkg::ROW_SEL_W-1:0]     row_sel,
    input  wire logic [aat_pkg::IN_TDATA_W-1:0]    req_data,
    input  wire logic [aat_pkg::DEPTH_BIAS_W-1:0]  depth_bias,
    output logic      [aat_pkg::OUT_TDATA_W-1:0]   res_data
);

    localparam int FW  = aat_pkg::FIELD_W;
    localparam int EW  = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
    localparam int MW  = (EW > FRAC_BITS + 2) ? EW : FRAC_BITS + 2;
    localparam int PW  = MW + EW;
    localparam int SHW = PW - FRAC_BITS;
    localparam int SW  = ((SHW > MW) ? SHW : MW) + 2;
    localparam int AW  = ((SW > aat_pkg::DEPTH_BIAS_W + 1) ? SW : aat_pkg::DEPTH_BIAS_W + 1) + 2;
    localparam int NA  = aat_pkg::NUM_AXES;
    localparam int NC  = aat_pkg::NUM_COEFS;

    localparam logic signed [AW-1:0] SAT_HI = {{(AW - EW + 1){1'b0}}, {(EW - 1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW - EW + 1){1'b1}}, {(EW - 1){1'b0}}};

    logic signed [MW-1:0]  mat_reg [NA][NC];
    logic signed [EW-1:0]  bmin_reg [NA];
    logic signed [EW-1:0]  bmax_reg [NA];

    logic signed [PW-1:0]  plo_reg [NA];
    logic signed [PW-1:0]  phi_reg [NA];
    logic signed [MW-1:0]  t1_reg;
    logic                  s1_valid_reg;
    logic [aat_pkg::AXIS_W-1:0] s1_axis_reg;

    logic signed [SHW-1:0] mn_reg [NA];
    logic signed [SHW-1:0] mx_reg [NA];
    logic signed [MW-1:0]  t2_reg;
    logic                  s2_valid_reg;
    logic [aat_pkg::AXIS_W-1:0] s2_axis_reg;

    logic signed [SW-1:0]  lo3_reg, hi3_reg;
    logic                  s3_valid_reg;
    logic [aat_pkg::AXIS_W-1:0] s3_axis_reg;

    logic signed [FW-1:0]  rmin_reg [NA];
    logic signed [FW-1:0]  rmax_reg [NA];
    logic [aat_pkg::OUT_TDATA_W-1:0] out_reg;

    logic signed [SHW-1:0] sh_lo [NA];
    logic signed [SHW-1:0] sh_hi [NA];
    logic signed [AW-1:0]  lo_w, hi_w, ext, bias_w, wlo, whi;
    logic signed [EW-1:0]  sat_lo, sat_hi;
    logic                  thin;

    // matrix store, identity after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NA; r++) begin
                for (int c = 0; c < NC; c++) begin
                    mat_reg[r][c] <= (r == c) ? (MW'(1) << FRAC_BITS) : '0;
                end
            end
        end else if (cmd.load && (row_sel != aat_pkg::ROW_NONE)) begin
            for (int c = 0; c < NC; c++) begin
                mat_reg[row_sel][c] <=
                    MW'($signed(req_data[(aat_pkg::SLOT_COEF_X + c) * FW +: EW]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int a = 0; a < NA; a++) begin
                bmin_reg[a] <= $signed(req_data[(aat_pkg::SLOT_BOX_MIN + a) * FW +: EW]);
                bmax_reg[a] <= $signed(req_data[(aat_pkg::SLOT_BOX_MAX + a) * FW +: EW]);
            end
        end
    end

    // pipeline valid and axis tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s1_axis_reg  <= '0;
            s2_axis_reg  <= '0;
            s3_axis_reg  <= '0;
        end else begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s1_axis_reg  <= cmd.axis;
            s2_axis_reg  <= s1_axis_reg;
            s3_axis_reg  <= s2_axis_reg;
        end
    end

    // stage 1: six products for one output axis
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            for (int j = 0; j < NA; j++) begin
                plo_reg[j] <= PW'(mat_reg[cmd.axis][j]) * PW'(bmin_reg[j]);
                phi_reg[j] <= PW'(mat_reg[cmd.axis][j]) * PW'(bmax_reg[j]);
            end
            t1_reg <= mat_reg[cmd.axis][aat_pkg::SLOT_COEF_T];
        end
    end

    // stage 2: floor shift, min and max per input coordinate
    always_comb begin
        for (int j = 0; j < NA; j++) begin
            sh_lo[j] = $signed(plo_reg[j][PW-1:FRAC_BITS]);
            sh_hi[j] = $signed(phi_reg[j][PW-1:FRAC_BITS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            for (int j = 0; j < NA; j++) begin
                mn_reg[j] <= (sh_lo[j] < sh_hi[j]) ? sh_lo[j] : sh_hi[j];
                mx_reg[j] <= (sh_lo[j] < sh_hi[j]) ? sh_hi[j] : sh_lo[j];
            end
            t2_reg <= t1_reg;
        end
    end

    // stage 3: row sums
    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            lo3_reg <= SW'(t2_reg) + SW'(mn_reg[0]) + SW'(mn_reg[1]) + SW'(mn_reg[2]);
            hi3_reg <= SW'(t2_reg) + SW'(mx_reg[0]) + SW'(mx_reg[1]) + SW'(mx_reg[2]);
        end
    end

    // stage 4: widen thin axes, saturate
    always_comb begin
        lo_w   = AW'(lo3_reg);
        hi_w   = AW'(hi3_reg);
        bias_w = $signed(AW'(depth_bias));
        ext    = hi_w - lo_w;
        thin   = ext < bias_w;
        wlo    = thin ? (lo_w - bias_w) : lo_w;
        whi    = thin ? (hi_w + bias_w) : hi_w;
        if (wlo > SAT_HI) begin
            sat_lo = SAT_HI[EW-1:0];
        end else if (wlo < SAT_LO) begin
            sat_lo = SAT_LO[EW-1:0];
        end else begin
            sat_lo = wlo[EW-1:0];
        end
        if (whi > SAT_HI) begin
            sat_hi = SAT_HI[EW-1:0];
        end else if (whi < SAT_LO) begin
            sat_hi = SAT_LO[EW-1:0];
        end else begin
            sat_hi = whi[EW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_valid_reg) begin
            rmin_reg[s3_axis_reg] <= FW'(sat_lo);
            rmax_reg[s3_axis_reg] <= FW'(sat_hi);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            for (int a = 0; a < NA; a++) begin
                out_reg[a * FW +: FW]        <= rmin_reg[a];
                out_reg[(NA + a) * FW +: FW] <= rmax_reg[a];
            end
        end
    end

    assign status.last_done =
        s3_valid_reg && (s3_axis_reg == aat_pkg::AXIS_W'(NA - 1));
    assign res_data = out_reg;

endmodule

`default_nettype wire

// File: hdl/aabb_affine_transform.sv
// ---------------------------------------------------------------------------
// aabb_affine_transform
// Transforms axis-aligned boxes by a stored 3x4 Q16.16 affine matrix.
// ---------------------------------------------------------------------------
// Request channel s_axis_*: tuser carries the request kind and the row
// select. A load request writes one matrix row (x, y, z, translation), or
// none for row select 3, and returns nothing. A box request carries min and
// max corners and returns one result on m_axis_*: per-axis min and max of
// the transformed corners, with thin axes widened by depth_bias and values
// saturated. A load request is taken while idle; the next request may follow
// at once. A box request runs through three issue steps (one output axis per
// cycle through six multipliers) and three pipeline stages behind them, then
// the transfer into the output register. s_axis_tready is low while a box is
// in flight, so no request is taken until its result has been loaded.
// A finished result waits in the output register while the next request is
// taken; a stalled receiver holds the following box in its final step.
// Reset (aresetn low, synchronous) loads the identity matrix, sets
// depth_bias to 655 and empties the output. depth_bias sits at APB
// address 0; write it only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module aabb_affine_transform #(
    parameter int FRAC_BITS   = aat_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // coef_x, coef_y, coef_z, coef_t, box_min_x, box_min_y, box_min_z,
    // box_max_x, box_max_y, box_max_z
    input  wire logic [aat_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // req_type, row_sel
    input  wire logic [aat_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic      [aat_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [aat_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [aat_pkg::PDATA_W-1:0]       pwdata,
    output logic      [aat_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready
);

    logic [aat_pkg::DEPTH_BIAS_W-1:0] depth_bias_reg;
    logic                             reg_hit;
    aat_pkg::cmd_t                    cmd;
    aat_pkg::status_t                 status;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[aat_pkg::PADDR_W-1:2] == aat_pkg::REG_DEPTH_BIAS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_bias_reg <= aat_pkg::DEPTH_BIAS_W'(aat_pkg::DEPTH_BIAS_RESET);
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            depth_bias_reg <= pwdata[aat_pkg::DEPTH_BIAS_W-1:0];
        end
    end

    assign prdata = reg_hit ? aat_pkg::PDATA_W'(depth_bias_reg) : '0;

    aat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .req_type (aat_pkg::req_type_t'(s_axis_tuser[0])),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    aat_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .row_sel    (s_axis_tuser[aat_pkg::IN_TUSER_W-1:1]),
        .req_data   (s_axis_tdata),
        .depth_bias (depth_bias_reg),
        .res_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/aat_checker.sv
// ---------------------------------------------------------------------------
// aat_checker
// Port-level checks of the box affine transform block, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module aat_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [aat_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [aat_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic box_req;
    logic load_req;

    assign box_req  = s_axis_tvalid && s_axis_tready &&
                      (s_axis_tuser[0] == aat_pkg::REQ_BOX);
    assign load_req = s_axis_tvalid && s_axis_tready &&
                      (s_axis_tuser[0] == aat_pkg::REQ_LOAD);

    `AAT_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")
    `AAT_ASSERT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result dropped or changed")
    `AAT_ASSERT(a_box_busy, aclk, aresetn, box_req |=> !s_axis_tready, "request taken while a box is in flight")
    `AAT_ASSERT(a_result_origin, aclk, aresetn, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result appeared without a box in flight")
    `AAT_ASSERT(a_load_silent, aclk, aresetn, load_req && !m_axis_tvalid |=> !m_axis_tvalid, "load request produced a result")

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: verif/aat_box_checker.sv
// ---------------------------------------------------------------------------
// aat_box_checker
// Watches the request, result and APB channels of aabb_affine_transform.
// It keeps its own copy of the matrix and depth bias, predicts the
// transformed box for every box request, and compares each result field by
// field with the oldest prediction.
// ---------------------------------------------------------------------------
module aat_box_checker #(
    parameter int FRAC_BITS = aat_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic [aat_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [aat_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [aat_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [aat_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [aat_pkg::PDATA_W-1:0]     pwdata,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   results_checked
);
    import aat_pkg::*;

    localparam logic [PADDR_W-1:0] BIAS_ADDR  = PADDR_W'(4 * REG_DEPTH_BIAS);
    localparam int                 OUT_FIELDS = 2 * NUM_AXES;
    localparam longint             FIELD_MAX  = (longint'(1) <<< (FIELD_W - 1)) - 1;
    localparam longint             FIELD_MIN  = -FIELD_MAX - 1;

    string result_fields [OUT_FIELDS] = '{
        "out_min_x", "out_min_y", "out_min_z", "out_max_x", "out_max_y", "out_max_z"
    };

    longint                  matrix_coef [NUM_AXES*NUM_COEFS];
    logic [DEPTH_BIAS_W-1:0] depth_bias;
    logic [OUT_TDATA_W-1:0]  expected_boxes [$];
    logic [OUT_TDATA_W-1:0]  oldest_box;
    int                      load_row;

    function automatic longint field_at(input logic [IN_TDATA_W-1:0] data, input int slot);
        return longint'($signed(data[FIELD_W*slot +: FIELD_W]));
    endfunction

    function automatic logic [FIELD_W-1:0] clamp_field(input longint v);
        if (v > FIELD_MAX) return FIELD_W'(FIELD_MAX);
        if (v < FIELD_MIN) return FIELD_W'(FIELD_MIN);
        return FIELD_W'(v);
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] transform_box(
        input logic [IN_TDATA_W-1:0] data
    );
        longint                 corner_min [NUM_AXES];
        longint                 corner_max [NUM_AXES];
        longint                 pt [NUM_AXES];
        longint                 lo [NUM_AXES];
        longint                 hi [NUM_AXES];
        longint                 acc;
        longint                 bias;
        logic [OUT_TDATA_W-1:0] bounds;
        bias = longint'(depth_bias);
        for (int a = 0; a < NUM_AXES; a++) begin
            corner_min[a] = field_at(data, SLOT_BOX_MIN + a);
            corner_max[a] = field_at(data, SLOT_BOX_MAX + a);
        end
        for (int c = 0; c < 8; c++) begin
            for (int a = 0; a < NUM_AXES; a++)
                pt[a] = c[a] ? corner_max[a] : corner_min[a];
            for (int r = 0; r < NUM_AXES; r++) begin
                acc = matrix_coef[NUM_COEFS*r + SLOT_COEF_T];
                for (int k = 0; k < NUM_AXES; k++)
                    acc += (matrix_coef[NUM_COEFS*r + k] * pt[k]) >>> FRAC_BITS;
                if (c == 0 || acc < lo[r]) lo[r] = acc;
                if (c == 0 || acc > hi[r]) hi[r] = acc;
            end
        end
        for (int r = 0; r < NUM_AXES; r++) begin
            if (hi[r] - lo[r] < bias) begin
                lo[r] -= bias;
                hi[r] += bias;
            end
            bounds[FIELD_W*r +: FIELD_W]            = clamp_field(lo[r]);
            bounds[FIELD_W*(r+NUM_AXES) +: FIELD_W] = clamp_field(hi[r]);
        end
        return bounds;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (matrix_coef[i]) matrix_coef[i] = 0;
            for (int r = 0; r < NUM_AXES; r++)
                matrix_coef[NUM_COEFS*r + r] = longint'(1) <<< FRAC_BITS;
            depth_bias = DEPTH_BIAS_W'(DEPTH_BIAS_RESET);
            expected_boxes.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == BIAS_ADDR)
                depth_bias = pwdata[DEPTH_BIAS_W-1:0];
            if (s_axis_tvalid && s_axis_tready) begin
                load_row = int'(s_axis_tuser[IN_TUSER_W-1:1]);
                if (req_type_t'(s_axis_tuser[0]) == REQ_BOX) begin
                    expected_boxes.push_back(transform_box(s_axis_tdata));
                end else if (s_axis_tuser[IN_TUSER_W-1:1] != ROW_NONE) begin
                    for (int k = 0; k < NUM_COEFS; k++)
                        matrix_coef[NUM_COEFS*load_row + k] =
                            field_at(s_axis_tdata, SLOT_COEF_X + k);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_boxes.size() == 0) begin
                    $error("box result with no box request outstanding");
                    fail_count++;
                end else begin
                    oldest_box = expected_boxes.pop_front();
                    results_checked++;
                    for (int f = 0; f < OUT_FIELDS; f++) begin
                        if (m_axis_tdata[FIELD_W*f +: FIELD_W] !== oldest_box[FIELD_W*f +: FIELD_W]) begin
                            $error("%s: expected %0d, got %0d", result_fields[f],
                                   $signed(oldest_box[FIELD_W*f +: FIELD_W]),
                                   $signed(m_axis_tdata[FIELD_W*f +: FIELD_W]));
                            fail_count++;
                        end
                    end
                end
            end
        end
        pending <= expected_boxes.size();
    end

endmodule

// File: verif/tb_aabb_affine_transform.sv
// ---------------------------------------------------------------------------
// tb_aabb_affine_transform
// Drives matrix row loads, box requests and depth bias writes into the box
// transform block under random sender gaps and receiver stalls. A directed
// opening covers identity, extreme coefficients and coordinates, inverted
// boxes, ignored row selects and saturation; random phases follow under
// several depth bias settings. aat_box_checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_aabb_affine_transform;
    import aat_pkg::*;

    localparam logic [PADDR_W-1:0] BIAS_ADDR     = PADDR_W'(4 * REG_DEPTH_BIAS);
    localparam logic [FIELD_W-1:0] Q_ONE         = 32'h0001_0000;
    localparam logic [FIELD_W-1:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] Q_MIN         = 32'h8000_0000;
    localparam int                 RANDOM_PHASES = 4;
    localparam int                 PHASE_ITEMS   = 110;
    localparam int                 SETTLE_CYCLES = 16;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire  [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [PADDR_W-1:0]     paddr         = '0;
    logic [PDATA_W-1:0]     pwdata        = '0;
    wire  [PDATA_W-1:0]     prdata;
    wire                    pready;

    logic quiet         = 1'b0;
    int   stall_left    = 0;
    int   loads_sent    = 0;
    int   boxes_sent    = 0;
    int   bias_settings = 1;
    int   fail_count;
    int   pending;
    int   results_checked;

    aabb_affine_transform DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    aat_box_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stall the result channel in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 10);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_request(input req_type_t kind, input logic [ROW_SEL_W-1:0] row,
                                input logic [IN_TDATA_W-1:0] data);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= {row, kind};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (kind == REQ_BOX) boxes_sent++;
        else loads_sent++;
    endtask

    task automatic send_box(input logic [FIELD_W-1:0] min_x, min_y, min_z,
                            input logic [FIELD_W-1:0] max_x, max_y, max_z);
        logic [IN_TDATA_W-1:0] data;
        for (int i = 0; i < IN_TDATA_W / FIELD_W; i++)
            data[FIELD_W*i +: FIELD_W] = $urandom;
        data[FIELD_W*SLOT_BOX_MIN +: 3*FIELD_W] = {min_z, min_y, min_x};
        data[FIELD_W*SLOT_BOX_MAX +: 3*FIELD_W] = {max_z, max_y, max_x};
        send_request(REQ_BOX, ROW_SEL_W'($urandom), data);
    endtask

    task automatic send_load(input logic [ROW_SEL_W-1:0] row,
                             input logic [FIELD_W-1:0] cx, cy, cz, ct);
        logic [IN_TDATA_W-1:0] data;
        for (int i = 0; i < IN_TDATA_W / FIELD_W; i++)
            data[FIELD_W*i +: FIELD_W] = $urandom;
        data[FIELD_W*SLOT_COEF_X +: 4*FIELD_W] = {ct, cz, cy, cx};
        send_request(REQ_LOAD, row, data);
    endtask

    function automatic logic [FIELD_W-1:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return FIELD_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return Q_ONE;
            default: return FIELD_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    task automatic send_random_box();
        logic [FIELD_W-1:0] lo [3];
        logic [FIELD_W-1:0] hi [3];
        logic [FIELD_W-1:0] swap;
        for (int a = 0; a < 3; a++) begin
            lo[a] = rand_coord();
            case ($urandom_range(0, 5))
                0:       hi[a] = lo[a];
                1:       hi[a] = lo[a] + $urandom_range(0, 1000);
                default: hi[a] = rand_coord();
            endcase
            if ($urandom_range(0, 7) != 0 && $signed(hi[a]) < $signed(lo[a])) begin
                swap  = lo[a];
                lo[a] = hi[a];
                hi[a] = swap;
            end
        end
        send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    task automatic send_random_load();
        logic [ROW_SEL_W-1:0] row;
        row = ($urandom_range(0, 9) == 0) ? ROW_NONE : ROW_SEL_W'($urandom_range(0, 2));
        send_load(row, rand_coef(), rand_coef(), rand_coef(), rand_coord());
    endtask

    // drain all results, then let the pipeline go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bias(input logic [PDATA_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BIAS_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bias_settings++;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_box('0, '0, '0, '0, '0, '0);
        send_box(Q_ONE, 32'hFFFD_0000, 32'h0007_0000, 32'h0002_0000, 32'h0005_0000,
                 32'h0007_0064);
        send_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        send_box(32'h0005_0000, 32'h0005_0000, Q_MAX, 32'hFFFB_0000, 32'hFFFB_0000, Q_MIN);
        send_load(ROW_NONE, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        send_box(Q_ONE, 32'hFFFD_0000, 32'h0007_0000, 32'h0002_0000, 32'h0005_0000,
                 32'h0007_0064);
        send_load(2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_load(2'd1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_load(2'd2, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_8000, Q_MIN);
        send_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        send_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h1);
        send_load(2'd0, Q_ONE, '0, '0, 32'h7FFF_FFF0);
        send_load(2'd1, '0, Q_ONE, '0, '0);
        send_load(2'd2, '0, '0, Q_ONE, 32'h8000_0010);
        send_box('0, '0, '0, '0, '0, '0);
        write_bias('1);
        send_box('0, '0, '0, '0, '0, '0);
        send_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        write_bias('0);
        send_box('0, '0, '0, '0, '0, '0);
        send_load(2'd0, 32'h0000_8000, 32'hFFFF_0000, '0, 32'h0003_0000);
        send_load(2'd2, '0, '0, Q_ONE, '0);
        send_box(32'hFFFF_0000, '0, 32'h0000_0001, Q_ONE, 32'h0002_0000, 32'h0000_0001);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       write_bias($urandom_range(0, 32'h0010_0000) |
                                    ($urandom_range(0, 1) << 31));
                1:       write_bias('0);
                2:       write_bias($urandom);
                default: begin
                    write_bias(DEPTH_BIAS_RESET);
                    quiet <= 1'b1;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 3) == 0) send_random_load();
                else send_random_box();
            end
        end

        settle();
        $display("sent %0d row loads and %0d boxes across %0d depth bias settings",
                 loads_sent, boxes_sent, bias_settings);
        $display("compared %0d transformed boxes field by field", results_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
